[rtl/core/sagp_pkg.sv]
package sagp_pkg;

  localparam int unsigned CompW = 32;
  localparam int unsigned MagW = 62;
  localparam int unsigned UnitW = 32;
  localparam int unsigned OutW = 17;
  localparam int unsigned CfgW = 31;
  localparam int unsigned NormShift = 30;
  localparam int unsigned DotShift = 44;
  localparam logic [OutW-1:0] OutOne = 17'd65536;

  typedef logic signed [MagW:0] vcomp_t;
  typedef vcomp_t vec3_t [3];
  typedef logic signed [UnitW-1:0] unit3_t [3];

  function automatic logic [5:0] norm_shift(input logic [MagW-1:0] mx);
    logic [5:0] s;
    s = 6'd0;
    for (int i = 0; i <= MagW - 31; i++) begin
      if ((mx >> i) >= 63'(64'h8000_0000)) begin
        s = 6'(i + 1);
      end
    end
    return s;
  endfunction

  function automatic logic signed [OutW:0] dot_clamp(input logic signed [65:0] d);
    logic signed [65:0] q;
    q = (d < 0) ? -((-d) >>> DotShift) : (d >>> DotShift);
    if (q > 66'sd65536) begin
      q = 66'sd65536;
    end
    if (q < -66'sd65536) begin
      q = -66'sd65536;
    end
    return q[OutW:0];
  endfunction

endpackage

[rtl/core/sagp_norm.sv]
module sagp_norm (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [63:0]         v_x,
  input  logic signed [63:0]         v_y,
  input  logic signed [63:0]         v_z,
  output logic signed [31:0]         n_x,
  output logic signed [31:0]         n_y,
  output logic signed [31:0]         n_z,
  output logic [63:0]                len
);
  import sagp_pkg::*;

  logic [62:0] mag [3];
  logic [2:0]  neg;
  logic [62:0] mx;

  always_comb begin
    mag[0] = v_x[63] ? 63'(-v_x) : 63'(v_x);
    mag[1] = v_y[63] ? 63'(-v_y) : 63'(v_y);
    mag[2] = v_z[63] ? 63'(-v_z) : 63'(v_z);
    neg = {v_z[63], v_y[63], v_x[63]};
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  // Stage 1: scale down.
  logic [30:0] sm_r [3];
  logic [2:0]  neg1_r;
  logic [5:0]  s1_r;
  logic [5:0]  sh;
  assign sh = norm_shift(mx[61:0]) + 6'(mx[62]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sm_r[i] <= 31'(mag[i] >> sh);
      neg1_r <= neg;
      s1_r <= sh;
    end
  end

  // Stage 2: squares, one register, then sum.
  logic [61:0] sq_r [3];
  logic [30:0] sm2_r [3];
  logic [2:0]  neg2_r;
  logic [5:0]  s2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 62'(sm_r[i]) * 62'(sm_r[i]);
        sm2_r[i] <= sm_r[i];
      end
      neg2_r <= neg1_r;
      s2_r <= s1_r;
    end
  end

  // Root: pipelined, two result bits per stage.
  localparam int unsigned RS = 16;
  logic [63:0] rx_r [RS+1];
  logic [63:0] rr_r [RS+1];
  logic [30:0] rm_r [RS+1][3];
  logic [2:0]  rn_r [RS+1];
  logic [5:0]  rs_r [RS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0] <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      rr_r[0] <= '0;
      rm_r[0] <= sm2_r;
      rn_r[0] <= neg2_r;
      rs_r[0] <= s2_r;
    end
  end

  for (genvar g = 0; g < RS; g++) begin : g_root
    logic [63:0] x, r, b;
    always_comb begin
      x = rx_r[g];
      r = rr_r[g];
      for (int k = 0; k < 2; k++) begin
        b = 64'd1 << (62 - 2 * (2 * g + k));
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[g+1] <= x;
        rr_r[g+1] <= r;
        rm_r[g+1] <= rm_r[g];
        rn_r[g+1] <= rn_r[g];
        rs_r[g+1] <= rs_r[g];
      end
    end
  end

  // Division: restoring, three quotient bits per stage, quotient < 2^32.
  localparam int unsigned DS = 11;
  logic [32:0] dl_r [DS+1];
  logic [63:0] dn_r [DS+1][3];
  logic [32:0] dq_r [DS+1][3];
  logic [63:0] dlen_r [DS+1];
  logic [2:0]  dneg_r [DS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= rr_r[RS][32:0];
      for (int i = 0; i < 3; i++) begin
        dn_r[0][i] <= 64'(rm_r[RS][i]) << NormShift;
        dq_r[0][i] <= '0;
      end
      dlen_r[0] <= rr_r[RS] << rs_r[RS];
      dneg_r[0] <= rn_r[RS];
    end
  end

  for (genvar g = 0; g < DS; g++) begin : g_div
    logic [63:0] rem [3];
    logic [32:0] q [3];
    logic [63:0] t;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem[i] = dn_r[g][i];
        q[i] = dq_r[g][i];
        for (int k = 0; k < 3; k++) begin
          if (32 - (3 * g + k) >= 0) begin
            t = 64'(dl_r[g]) << (32 - (3 * g + k));
            q[i] = q[i] << 1;
            if (dl_r[g] != 0 && rem[i] >= t) begin
              rem[i] = rem[i] - t;
              q[i][0] = 1'b1;
            end
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dl_r[g+1] <= dl_r[g];
        dn_r[g+1] <= rem;
        dq_r[g+1] <= q;
        dlen_r[g+1] <= dlen_r[g];
        dneg_r[g+1] <= dneg_r[g];
      end
    end
  end

  assign n_x = dneg_r[DS][0] ? -32'(dq_r[DS][0]) : 32'(dq_r[DS][0]);
  assign n_y = dneg_r[DS][1] ? -32'(dq_r[DS][1]) : 32'(dq_r[DS][1]);
  assign n_z = dneg_r[DS][2] ? -32'(dq_r[DS][2]) : 32'(dq_r[DS][2]);
  assign len = dlen_r[DS];

endmodule

[rtl/core/spatial_audio_gain_pan.sv]
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | source, listener, facing, up (x, y, z)
// out     | output    | out_valid/out_ready | gain, pan
// cfg     | input     | cfg_we              | cfg_max_distance
// A request can enter every cycle while the output is not stalled.
// Each result passes through the input register, two chained 31-stage normalizers with two product
// stages between them, one dot-product stage and the output register.
// The gain divider runs alongside the second normalizer and adds no latency.
// Reset (synchronous, rst_n low) clears all valid bits and sets max_distance to 10.0.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module spatial_audio_gain_pan #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_source_x,
  input  logic signed [31:0] in_source_y,
  input  logic signed [31:0] in_source_z,
  input  logic signed [31:0] in_listener_x,
  input  logic signed [31:0] in_listener_y,
  input  logic signed [31:0] in_listener_z,
  input  logic signed [31:0] in_facing_x,
  input  logic signed [31:0] in_facing_y,
  input  logic signed [31:0] in_facing_z,
  input  logic signed [31:0] in_up_x,
  input  logic signed [31:0] in_up_y,
  input  logic signed [31:0] in_up_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_gain,
  output logic [16:0] out_pan,
  input  logic        cfg_we,
  input  logic [30:0] cfg_max_distance
);
  import sagp_pkg::*;

  localparam logic [30:0] MaxReset = 31'(10 << FRAC_BITS);
  localparam int unsigned NL = 3 + 16 + 1 + 11;
  localparam int unsigned GS = 17;
  localparam int unsigned Depth = 2 * NL + 5;

  logic [30:0] max_r;
  logic [Depth-1:0] vld_r;
  logic en;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MaxReset;
      vld_r <= '0;
    end else begin
      if (cfg_we) max_r <= cfg_max_distance;
      if (en) vld_r <= {vld_r[Depth-2:0], in_valid};
    end
  end

  // Input stage.
  logic signed [63:0] dir_r [3], fw_r [3], up_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      dir_r[0] <= 64'(in_source_x) - 64'(in_listener_x);
      dir_r[1] <= 64'(in_source_y) - 64'(in_listener_y);
      dir_r[2] <= 64'(in_source_z) - 64'(in_listener_z);
      fw_r[0] <= 64'(in_facing_x) - 64'(in_listener_x);
      fw_r[1] <= 64'(in_facing_y) - 64'(in_listener_y);
      fw_r[2] <= 64'(in_facing_z) - 64'(in_listener_z);
      up_r[0] <= 64'(in_up_x);
      up_r[1] <= 64'(in_up_y);
      up_r[2] <= 64'(in_up_z);
    end
  end

  logic signed [31:0] nd [3], nf [3], nu [3];
  logic [63:0] dir_len, len_f, len_u;

  sagp_norm u_nd (.clk, .en, .v_x(dir_r[0]), .v_y(dir_r[1]), .v_z(dir_r[2]),
    .n_x(nd[0]), .n_y(nd[1]), .n_z(nd[2]), .len(dir_len));
  sagp_norm u_nf (.clk, .en, .v_x(fw_r[0]), .v_y(fw_r[1]), .v_z(fw_r[2]),
    .n_x(nf[0]), .n_y(nf[1]), .n_z(nf[2]), .len(len_f));
  sagp_norm u_nu (.clk, .en, .v_x(up_r[0]), .v_y(up_r[1]), .v_z(up_r[2]),
    .n_x(nu[0]), .n_y(nu[1]), .n_z(nu[2]), .len(len_u));

  // Products after first normalization.
  logic signed [63:0] pc_r [6];
  logic signed [63:0] pf_r [3];
  logic signed [31:0] nd1_r [3];
  logic [63:0] dist1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pc_r[0] <= 64'(nu[1]) * 64'(nf[2]);
      pc_r[1] <= 64'(nu[2]) * 64'(nf[1]);
      pc_r[2] <= 64'(nu[2]) * 64'(nf[0]);
      pc_r[3] <= 64'(nu[0]) * 64'(nf[2]);
      pc_r[4] <= 64'(nu[0]) * 64'(nf[1]);
      pc_r[5] <= 64'(nu[1]) * 64'(nf[0]);
      for (int i = 0; i < 3; i++) pf_r[i] <= 64'(nf[i]) * 64'(nd[i]);
      nd1_r <= nd;
      dist1_r <= dir_len;
    end
  end

  logic signed [63:0] cr_r [3];
  logic signed [OutW:0] dotf_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= pc_r[0] - pc_r[1];
      cr_r[1] <= pc_r[2] - pc_r[3];
      cr_r[2] <= pc_r[4] - pc_r[5];
      dotf_r <= dot_clamp(66'(pf_r[0]) + 66'(pf_r[1]) + 66'(pf_r[2]));
    end
  end

  // Gain division runs alongside the right-vector normalizer.
  logic [47:0] gn_r [GS+1];
  logic [33:0] gd_r [GS+1];
  logic [16:0] gq_r [GS+1];
  logic [33:0] gsum;
  assign gsum = 34'(max_r == '0 ? 31'd1 : max_r) + dist1_r[33:0];
  always_ff @(posedge clk) begin
    if (en) begin
      gn_r[0] <= 48'(max_r == '0 ? 31'd1 : max_r) << 16;
      gd_r[0] <= gsum;
      gq_r[0] <= '0;
    end
  end
  for (genvar g = 0; g < GS; g++) begin : g_gdiv
    logic [80:0] t;
    logic [47:0] rem;
    logic [16:0] q;
    always_comb begin
      t = 81'(gd_r[g]) << (16 - g);
      rem = gn_r[g];
      q = gq_r[g];
      q[16-g] = 1'b0;
      if (81'(rem) >= t) begin
        rem = rem - 48'(t);
        q[16-g] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        gn_r[g+1] <= rem;
        gd_r[g+1] <= gd_r[g];
        gq_r[g+1] <= q;
      end
    end
  end

  logic signed [31:0] nr [3];
  logic [63:0] len_r;
  sagp_norm u_nr (.clk, .en, .v_x(cr_r[0]), .v_y(cr_r[1]), .v_z(cr_r[2]),
    .n_x(nr[0]), .n_y(nr[1]), .n_z(nr[2]), .len(len_r));

  // Delay lines for direction, forward dot and gain alongside u_nr.
  localparam int unsigned DL = NL + 2;
  logic signed [31:0] ndd_r [DL][3];
  logic signed [OutW:0] dfd_r [DL];
  logic [16:0] gdl_r [DL];
  always_ff @(posedge clk) begin
    if (en) begin
      ndd_r[0] <= nd1_r;
      dfd_r[0] <= dotf_r;
      gdl_r[0] <= gq_r[GS];
      for (int i = 1; i < DL; i++) begin
        ndd_r[i] <= ndd_r[i-1];
        dfd_r[i] <= dfd_r[i-1];
        gdl_r[i] <= (i == GS + 1) ? gq_r[GS] : gdl_r[i-1];
      end
    end
  end

  logic signed [63:0] pr_r [3];
  logic [33:0] gp_r;
  logic signed [OutW:0] dfa_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) pr_r[i] <= 64'(ndd_r[DL-2][i]) * 64'(nr[i]);
      gp_r <= 34'(gdl_r[DL-2]) * 34'(17'(OutOne + 17'(dfd_r[DL-3] / 2)));
      dfa_r <= dfd_r[DL-3];
    end
  end

  logic signed [OutW:0] dotr;
  logic signed [OutW+1:0] pan;
  logic [33:0] g2;
  always_comb begin
    dotr = dot_clamp(66'(pr_r[0]) + 66'(pr_r[1]) + 66'(pr_r[2]));
    pan = 19'sd32768 + 19'(dotr / 2);
    g2 = (dfa_r < 0) ? (gp_r >> 16) : 34'(gdl_r[DL-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_gain <= g2 > 34'(OutOne) ? OutOne : g2[16:0];
      out_pan <= pan < 0 ? '0 : (pan > 19'sd65536 ? OutOne : pan[16:0]);
    end
  end

  logic unused;
  assign unused = ^{len_f, len_u, len_r, dist1_r[63:34]};

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain <= OutOne) else $error("gain above unity");
  a_pan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pan <= OutOne) else $error("pan above unity");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gain))
    else $error("output changed under stall");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");

endmodule

[tb/spatial_audio_gain_pan_tb.sv]
`timescale 1ns / 100ps

module spatial_audio_gain_pan_tb;
  import sagp_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int DrainCycles = 120;
  localparam int PhaseItems = 250;
  localparam logic [30:0] MaxDistReset = 31'd655360;
  localparam int Q1 = 65536;

  typedef struct {
    logic signed [31:0] src[3];
    logic signed [31:0] lsn[3];
    logic signed [31:0] fac[3];
    logic signed [31:0] up[3];
  } geom_t;

  typedef struct {
    logic [OutW-1:0] gain;
    logic [OutW-1:0] pan;
  } mix_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_source_x, in_source_y, in_source_z;
  logic signed [31:0] in_listener_x, in_listener_y, in_listener_z;
  logic signed [31:0] in_facing_x, in_facing_y, in_facing_z;
  logic signed [31:0] in_up_x, in_up_y, in_up_z;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [16:0] out_gain;
  logic [16:0] out_pan;
  logic cfg_we;
  logic [30:0] cfg_max_distance;

  mix_t expected_mix[$];
  logic [30:0] max_dist_shadow;
  int error_count = 0;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles = 0;

  spatial_audio_gain_pan u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_x      (in_source_x),
    .in_source_y      (in_source_y),
    .in_source_z      (in_source_z),
    .in_listener_x    (in_listener_x),
    .in_listener_y    (in_listener_y),
    .in_listener_z    (in_listener_z),
    .in_facing_x      (in_facing_x),
    .in_facing_y      (in_facing_y),
    .in_facing_z      (in_facing_z),
    .in_up_x          (in_up_x),
    .in_up_y          (in_up_y),
    .in_up_z          (in_up_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_gain         (out_gain),
    .out_pan          (out_pan),
    .cfg_we           (cfg_we),
    .cfg_max_distance (cfg_max_distance)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Returns the vector length and writes the Q2.30 unit vector.
  function automatic longint unsigned unit_vec(input longint v[3], output longint n[3]);
    longint unsigned mag[3];
    longint unsigned mx;
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    int s;
    mx = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? 64'd0 - longint'(v[i]) : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    while ((mx >> s) >= (64'd1 << 31)) s++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      sum = sum + mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (len == 0) ? 64'd0 : (mag[i] << NormShift) / len;
      n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return len << s;
  endfunction

  function automatic longint dot_q16(input longint a[3], input longint b[3]);
    longint d;
    d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    d = d / (longint'(1) << DotShift);
    if (d > Q1) d = Q1;
    if (d < -Q1) d = -Q1;
    return d;
  endfunction

  function automatic mix_t predict_mix(input geom_t g, input logic [30:0] max_dist);
    longint dir[3], fw[3], upv[3], cr[3];
    longint ndir[3], nfw[3], nup[3], nright[3];
    longint unsigned src_range, mx, gain;
    longint dotf, dotr, pan;
    mix_t r;
    for (int i = 0; i < 3; i++) begin
      dir[i] = longint'(g.src[i]) - longint'(g.lsn[i]);
      fw[i] = longint'(g.fac[i]) - longint'(g.lsn[i]);
      upv[i] = longint'(g.up[i]);
    end
    src_range = unit_vec(dir, ndir);
    void'(unit_vec(fw, nfw));
    void'(unit_vec(upv, nup));
    cr[0] = nup[1] * nfw[2] - nup[2] * nfw[1];
    cr[1] = nup[2] * nfw[0] - nup[0] * nfw[2];
    cr[2] = nup[0] * nfw[1] - nup[1] * nfw[0];
    void'(unit_vec(cr, nright));
    mx = (max_dist == 0) ? 64'd1 : 64'(max_dist);
    gain = (mx * 64'd65536) / (mx + src_range);
    dotf = dot_q16(nfw, ndir);
    if (dotf < 0) begin
      gain = (gain * 64'(Q1 + dotf / 2)) >> 16;
    end
    if (gain > Q1) gain = Q1;
    dotr = dot_q16(ndir, nright);
    pan = Q1 / 2 + dotr / 2;
    if (pan < 0) pan = 0;
    if (pan > Q1) pan = Q1;
    r.gain = gain[OutW-1:0];
    r.pan = pan[OutW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_request(input geom_t g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_source_x <= g.src[0];
    in_source_y <= g.src[1];
    in_source_z <= g.src[2];
    in_listener_x <= g.lsn[0];
    in_listener_y <= g.lsn[1];
    in_listener_z <= g.lsn[2];
    in_facing_x <= g.fac[0];
    in_facing_y <= g.fac[1];
    in_facing_z <= g.fac[2];
    in_up_x <= g.up[0];
    in_up_y <= g.up[1];
    in_up_z <= g.up[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_mix = {expected_mix, predict_mix(g, max_dist_shadow)};
  endtask

  task automatic write_max_distance(input logic [30:0] value);
    in_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_max_distance <= value;
    max_dist_shadow = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic geom_t make_geom(input int sx, input int sy, input int sz,
                                      input int lx, input int ly, input int lz,
                                      input int fx, input int fy, input int fz,
                                      input int ux, input int uy, input int uz);
    geom_t g;
    g.src = '{sx, sy, sz};
    g.lsn = '{lx, ly, lz};
    g.fac = '{fx, fy, fz};
    g.up = '{ux, uy, uz};
    return g;
  endfunction

  function automatic logic signed [31:0] rand_coord(input int style);
    logic signed [31:0] v;
    case (style)
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      2: begin
        case ($urandom_range(5))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 0;
          3: v = -1;
          4: v = 1;
          default: v = Q1;
        endcase
      end
      default: v = $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
    endcase
    return v;
  endfunction

  function automatic geom_t rand_geom();
    geom_t g;
    int style;
    int pick;
    style = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      g.src[i] = rand_coord(style);
      g.lsn[i] = rand_coord(style);
      g.fac[i] = rand_coord(style);
      g.up[i] = rand_coord(style);
    end
    pick = $urandom_range(19);
    if (pick == 0) g.src = g.lsn;
    if (pick == 1) g.fac = g.lsn;
    if (pick == 2) g.up = '{0, 0, 0};
    if (pick == 3) g.up = '{g.fac[0] - g.lsn[0], g.fac[1] - g.lsn[1], g.fac[2] - g.lsn[2]};
    return g;
  endfunction

  task automatic test_directed_geometry();
    geom_t g[$];
    g = {g, make_geom(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    g = {g, make_geom(5 * Q1, 0, 0, 5 * Q1, 0, 0, 5 * Q1, 0, -Q1, 0, Q1, 0)};
    g = {g, make_geom(0, 0, -10 * Q1, 0, 0, 0, 0, 0, -Q1, 0, Q1, 0)};
    g = {g, make_geom(0, 0, 10 * Q1, 0, 0, 0, 0, 0, -Q1, 0, Q1, 0)};
    g = {g, make_geom(3 * Q1, 0, 3 * Q1, 0, 0, 0, 0, 0, -Q1, 0, Q1, 0)};
    g = {g, make_geom(-Q1, 0, 0, 0, 0, 0, 0, 0, -Q1, 0, Q1, 0)};
    g = {g, make_geom(Q1, 0, 0, 0, 0, 0, 0, 0, -Q1, 0, Q1, 0)};
    g = {g, make_geom(Q1, 2 * Q1, 0, 0, 0, 0, 0, 0, -Q1, 0, 0, 0)};
    g = {g, make_geom(Q1, 0, Q1, 7, 7, 7, 7, 7, 7, 0, Q1, 0)};
    g = {g, make_geom(Q1, 0, 0, 0, 0, 0, 0, 0, -Q1, 0, 0, -Q1)};
    g = {g, make_geom(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000)};
    g = {g, make_geom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff)};
    g = {g, make_geom(-1, -1, -1, 0, 0, 0, 1, 0, 0, 0, 0, 1)};
    g = {g, make_geom(1, 0, 0, 0, 0, 0, -1, 0, 0, 0, 1, 0)};
    g = {g, make_geom(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0,
                      32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 0)};
    g = {g, make_geom(0, 32'h8000_0000, 0, 0, 0, 0, 0, 32'h7fff_ffff, 0,
                      32'h8000_0000, 0, 0)};
    foreach (g[i]) send_request(g[i]);
  endtask

  task automatic test_random_geometry(input int count);
    for (int i = 0; i < count; i++) send_request(rand_geom());
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    mix_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_mix.size() == 0) begin
        report_mismatch("gain of an unexpected result", out_gain, '0);
      end else begin
        want = expected_mix.pop_front();
        if (out_gain !== want.gain) report_mismatch("gain", out_gain, want.gain);
        if (out_pan !== want.pan) report_mismatch("pan", out_pan, want.pan);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("spatial_audio_gain_pan_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_source_x = 0;
    in_source_y = 0;
    in_source_z = 0;
    in_listener_x = 0;
    in_listener_y = 0;
    in_listener_z = 0;
    in_facing_x = 0;
    in_facing_y = 0;
    in_facing_z = 0;
    in_up_x = 0;
    in_up_y = 0;
    in_up_z = 0;
    cfg_we = 1'b0;
    cfg_max_distance = 0;
    send_idle_pct = 17;
    recv_stall_pct = 51;
    max_dist_shadow = MaxDistReset;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_geometry();
    write_max_distance(31'd1);
    test_directed_geometry();
    write_max_distance(31'h7fff_ffff);
    test_directed_geometry();

    write_max_distance(MaxDistReset);
    test_random_geometry(PhaseItems);
    send_idle_pct = 51;
    recv_stall_pct = 17;
    write_max_distance(31'($urandom_range(1, 32'h0100_0000)));
    test_random_geometry(PhaseItems);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_max_distance(31'($urandom_range(1, 32'h7fff_ffff)));
    test_random_geometry(PhaseItems);

    in_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("spatial_audio_gain_pan_tb: done, clean");
    end else begin
      $display("spatial_audio_gain_pan_tb: done, errors");
    end
    $finish;
  end

endmodule
